[src/tea_pkg.sv]
`default_nettype none

package tea_pkg;

  localparam int NODE_W = 8;
  localparam int TIME_W = 31;
  localparam int CFG_ADDR_W = 2;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_NODE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_START = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_END   = 2'd2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [1:0]        action;
    logic [NODE_W-1:0] edge_from;
    logic [NODE_W-1:0] edge_to;
    logic [TIME_W-1:0] depart_time;
    logic [TIME_W-1:0] arrive_time;
    logic [NODE_W-1:0] query_node;
  } item_t;

  typedef struct packed {
    logic              stopped;
    logic              reached;
    logic [TIME_W-1:0] arrival_time;
    logic [NODE_W-1:0] node;
    logic              updated;
  } result_t;

endpackage

`default_nettype wire

[src/tea_table.sv]
`default_nettype none

module tea_table #(
  parameter int DEPTH = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]       rd_a_addr,
  input  wire logic [$clog2(DEPTH)-1:0]       rd_b_addr,
  output logic      [tea_pkg::TIME_W-1:0]     rd_a_data,
  output logic      [tea_pkg::TIME_W-1:0]     rd_b_data,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  wire logic [tea_pkg::TIME_W-1:0]     wr_data
);
  import tea_pkg::*;

  logic [TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

`default_nettype wire

[src/temporal_earliest_arrival_top.sv]
`default_nettype none

// Earliest-arrival search over a temporal edge stream fed in departure order.
// A start beat (tuser 0) clears the reached map and puts the configured source
// at time 0; an edge beat (tuser 1) relaxes its to-node; a query beat (tuser 2
// or 3) reads one node. Every beat gives exactly one result beat. The block
// takes one beat per clock unless the output stalls; an accepted beat is held
// in s1 until its result beat is registered, and the arrival table read is
// registered on the input beat's edge (one write port, two read ports: from-node
// and to/query node). Back-to-back writes are forwarded, so dependent edges may
// follow each other in consecutive cycles. The arrival table has no reset and
// needs no clearing; the reached map is flops cleared at once by reset and by a
// start beat. Configuration may be written only while the block is empty.
module temporal_earliest_arrival_top #(
  parameter int NODES = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // edge_from, edge_to, depart_time, arrive_time, query_node, zero pad
  input  wire logic [87:0]                     in_tdata,
  // action
  input  wire logic [1:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // updated, node, arrival_time, reached, stopped, zero pad
  output logic      [47:0]                     out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tea_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [tea_pkg::TIME_W-1:0]      cfg_data
);
  import tea_pkg::*;

  localparam int DEPTH = (NODES < 256) ? NODES : 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [31:0] NODES_U = 32'(NODES);

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    node_ok = {{(32-NODE_W){1'b0}}, n} < NODES_U;
  endfunction

  // configuration
  logic [NODE_W-1:0] source_node_r;
  logic [TIME_W-1:0] window_start_r;
  logic [TIME_W-1:0] window_end_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_node_r  <= '0;
      window_start_r <= '0;
      window_end_r   <= TIME_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_SOURCE_NODE:  source_node_r  <= cfg_data[NODE_W-1:0];
        CFG_WINDOW_START: window_start_r <= cfg_data;
        CFG_WINDOW_END:   window_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and stage control
  item_t   in_item;
  item_t   s1_r;
  logic    s1_valid_r;
  logic    out_valid_r;
  result_t out_r;
  result_t res;
  logic    in_fire;
  logic    s1_adv;

  assign in_item.action      = in_tuser;
  assign in_item.edge_from   = in_tdata[7:0];
  assign in_item.edge_to     = in_tdata[15:8];
  assign in_item.depart_time = in_tdata[46:16];
  assign in_item.arrive_time = in_tdata[77:47];
  assign in_item.query_node  = in_tdata[85:78];

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r};

  // arrival table
  logic [IDX_W-1:0]  rd_a_addr;
  logic [IDX_W-1:0]  rd_b_addr;
  logic [TIME_W-1:0] rd_a_data;
  logic [TIME_W-1:0] rd_b_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [TIME_W-1:0] wr_data;

  assign rd_a_addr = in_item.edge_from[IDX_W-1:0];
  assign rd_b_addr = (in_item.action == ACT_EDGE) ? in_item.edge_to[IDX_W-1:0]
                                                  : in_item.query_node[IDX_W-1:0];

  tea_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // write seen at the read edge, forwarded to the item that read there
  logic              fwd_valid_r;
  logic [IDX_W-1:0]  fwd_addr_r;
  logic [TIME_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (in_fire) begin
      fwd_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

  // pass state
  logic [DEPTH-1:0] rmap_r;
  logic [DEPTH-1:0] rmap_nxt;
  logic             stopped_r;
  logic             stopped_nxt;

  always_comb begin
    logic [IDX_W-1:0]  from_idx;
    logic [IDX_W-1:0]  to_idx;
    logic [IDX_W-1:0]  q_idx;
    logic [IDX_W-1:0]  src_idx;
    logic [TIME_W-1:0] tbl_from;
    logic [TIME_W-1:0] tbl_b;
    logic              from_reached;
    logic              b_reached;
    logic              relax_ok;
    logic              do_upd;
    logic              stop_set;

    from_idx = s1_r.edge_from[IDX_W-1:0];
    to_idx   = s1_r.edge_to[IDX_W-1:0];
    q_idx    = s1_r.query_node[IDX_W-1:0];
    src_idx  = source_node_r[IDX_W-1:0];

    tbl_from = (fwd_valid_r && fwd_addr_r == from_idx) ? fwd_data_r : rd_a_data;
    tbl_b    = rd_b_data;
    if (s1_r.action == ACT_EDGE) begin
      if (fwd_valid_r && fwd_addr_r == to_idx) begin
        tbl_b = fwd_data_r;
      end
    end else if (fwd_valid_r && fwd_addr_r == q_idx) begin
      tbl_b = fwd_data_r;
    end

    from_reached = node_ok(s1_r.edge_from) && rmap_r[from_idx];
    relax_ok = (s1_r.depart_time >= window_start_r) &&
               (s1_r.arrive_time <= window_end_r) &&
               from_reached && (s1_r.depart_time >= tbl_from) &&
               node_ok(s1_r.edge_to);
    b_reached = 1'b0;
    do_upd    = 1'b0;
    stop_set  = 1'b0;

    rmap_nxt    = rmap_r;
    stopped_nxt = stopped_r;
    wr_en       = 1'b0;
    wr_addr     = to_idx;
    wr_data     = s1_r.arrive_time;

    res.updated      = 1'b0;
    res.node         = s1_r.query_node;
    res.arrival_time = '0;
    res.reached      = 1'b0;
    res.stopped      = stopped_r;

    if (s1_r.action == ACT_START) begin
      res.node    = source_node_r;
      res.reached = node_ok(source_node_r);
      res.stopped = 1'b0;
      stopped_nxt = 1'b0;
      rmap_nxt    = '0;
      if (node_ok(source_node_r)) begin
        rmap_nxt[src_idx] = 1'b1;
        wr_en   = s1_adv;
        wr_addr = src_idx;
        wr_data = '0;
      end
    end else if (s1_r.action == ACT_EDGE) begin
      b_reached = node_ok(s1_r.edge_to) && rmap_r[to_idx];
      do_upd    = !stopped_r && relax_ok &&
                  (!b_reached || s1_r.arrive_time < tbl_b);
      stop_set  = !stopped_r && !relax_ok && (s1_r.depart_time > window_end_r);
      res.node  = s1_r.edge_to;
      res.updated = do_upd;
      res.reached = b_reached || do_upd;
      if (do_upd) begin
        res.arrival_time = s1_r.arrive_time;
        rmap_nxt[to_idx] = 1'b1;
        wr_en = s1_adv;
      end else if (b_reached) begin
        res.arrival_time = tbl_b;
      end
      stopped_nxt = stopped_r || stop_set;
      res.stopped = stopped_nxt;
    end else begin
      b_reached   = node_ok(s1_r.query_node) && rmap_r[q_idx];
      res.reached = b_reached;
      if (b_reached) begin
        res.arrival_time = tbl_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rmap_r      <= '0;
      stopped_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        rmap_r      <= rmap_nxt;
        stopped_r   <= stopped_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_item;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  // checks
  a_stop_from_edge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stopped_r) |-> $past(s1_adv && s1_r.action == ACT_EDGE))
    else $error("stop flag set by a beat that is not an edge");

  a_start_clears_stop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_r.action == ACT_START |=> !stopped_r)
    else $error("start beat left the pass stopped");

  a_update_reached: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.updated |-> out_r.reached)
    else $error("updated result not marked reached");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted while both stages are held");

  a_write_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> s1_adv && s1_r.action != ACT_QUERY)
    else $error("table written outside an advancing start or edge");

endmodule

`default_nettype wire
